// File: hw/rtl/rsdn_pkg.sv
// Shared types and constants for the row successive-difference norm block.
// No dependencies; used by every module under hw/rtl but rsdn_queue.
`default_nettype none

package rsdn_pkg;

  localparam int LEN_W      = 13;  // row_length register
  localparam int GAIN_W     = 24;  // gain register, unsigned Q8.16
  localparam int BATCH_W    = 32;  // batch_rows register and row counter
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_W      = 32;  // ic_value width
  localparam int FRAC_BITS  = 8;   // fractional bits dropped from the product before the divide
  localparam int QUEUE_DEPTH = 4;
  localparam int CNT_W      = 5;   // iteration counter, up to 32 steps

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_ROWS = 2'd2;

  localparam logic [LEN_W-1:0]   ROW_LENGTH_RST = 13'd2;
  localparam logic [GAIN_W-1:0]  GAIN_RST       = 24'd65536;
  localparam logic [BATCH_W-1:0] BATCH_ROWS_RST = 32'd1;
  localparam logic [LEN_W-1:0]   MIN_ROW_LENGTH = 13'd2;

  // Per-row control carried from the front end to the back end.
  typedef struct packed {
    logic [LEN_W-1:0]  len_m1;  // row length minus one, the divisor
    logic [GAIN_W-1:0] gain;
    logic              last;    // row closes a batch
  } row_ctrl_t;

  localparam int CTRL_W = $bits(row_ctrl_t);

endpackage

`default_nettype wire

// File: hw/rtl/rsdn_queue.sv
// Small register FIFO between the front end and the back end.
// Depends on nothing but its parameters.
`default_nettype none

module rsdn_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic [DATA_W-1:0] push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   pop_valid,
  output logic [DATA_W-1:0]      pop_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign pop_valid = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

`default_nettype wire

// File: hw/rtl/rsdn_front.sv
// Front end: takes sample beats, tracks row/batch position, squares the
// successive differences and accumulates them; pushes one entry per row.
// Depends on rsdn_pkg.
`default_nettype none

module rsdn_front #(
  parameter int SAMPLE_W = 16,
  parameter int MAX_LEN  = 4096,
  parameter int SUM_W    = 44
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic signed [SAMPLE_W-1:0]   in_sample,
  input  wire logic [rsdn_pkg::LEN_W-1:0]   row_length,
  input  wire logic [rsdn_pkg::GAIN_W-1:0]  gain,
  input  wire logic [rsdn_pkg::BATCH_W-1:0] batch_rows,
  input  wire logic                         q_full,
  output logic                              q_push,
  output logic [SUM_W+rsdn_pkg::CTRL_W-1:0] q_data
);

  localparam int LEN_W = rsdn_pkg::LEN_W;
  localparam int SQ_W  = 2 * SAMPLE_W;

  logic [LEN_W-1:0]             idx_r;
  logic [rsdn_pkg::BATCH_W-1:0] row_r;
  logic [SAMPLE_W-1:0]          prev_r;
  logic [SUM_W-1:0]             sum_r;

  logic                s1_v_r, s1_first_r, s1_end_r;
  logic [SAMPLE_W-1:0] s1_mag_r;
  rsdn_pkg::row_ctrl_t s1_ctrl_r;
  logic                s2_v_r, s2_first_r, s2_end_r;
  logic [SQ_W-1:0]     s2_sq_r;
  rsdn_pkg::row_ctrl_t s2_ctrl_r;

  logic                adv, take, row_end, batch_last;
  logic [LEN_W-1:0]    n_eff;
  logic signed [SAMPLE_W:0] diff;
  logic [SAMPLE_W-1:0] mag;
  logic [SQ_W-1:0]     sq_eff;
  logic [SUM_W:0]      acc_ext;
  logic [SUM_W-1:0]    acc;
  rsdn_pkg::row_ctrl_t ctrl;

  // Pipeline stalls only when a row-end entry cannot enter the queue.
  assign adv      = !(s2_v_r && s2_end_r && q_full);
  assign in_ready = adv;
  assign take     = in_valid && adv;

  always_comb begin
    if (row_length < rsdn_pkg::MIN_ROW_LENGTH)
      n_eff = rsdn_pkg::MIN_ROW_LENGTH;
    else if (32'(row_length) > 32'(MAX_LEN))
      n_eff = LEN_W'(MAX_LEN);
    else
      n_eff = row_length;
  end

  assign row_end    = ({1'b0, idx_r} + 1'b1) >= {1'b0, n_eff};
  assign batch_last = ({1'b0, row_r} + 1'b1) >= {1'b0, batch_rows};

  assign diff = $signed({in_sample[SAMPLE_W-1], in_sample})
              - $signed({prev_r[SAMPLE_W-1], prev_r});
  assign mag  = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];

  always_comb begin
    ctrl.len_m1 = n_eff - 1'b1;
    ctrl.gain   = gain;
    ctrl.last   = batch_last;
  end

  // Saturating accumulate; the first sample of a row adds nothing.
  assign sq_eff  = s2_first_r ? '0 : s2_sq_r;
  assign acc_ext = {1'b0, sum_r} + (SUM_W+1)'(sq_eff);
  assign acc     = acc_ext[SUM_W] ? '1 : acc_ext[SUM_W-1:0];

  assign q_push = s2_v_r && s2_end_r && adv;
  assign q_data = {s2_ctrl_r, acc};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r  <= '0;
      row_r  <= '0;
      prev_r <= '0;
      sum_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (take) begin
        prev_r <= in_sample;
        idx_r  <= row_end ? '0 : idx_r + 1'b1;
        if (row_end) row_r <= batch_last ? '0 : row_r + 1'b1;
      end
      if (adv) begin
        s1_v_r <= take;
        s2_v_r <= s1_v_r;
        if (s2_v_r) sum_r <= s2_end_r ? '0 : acc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mag_r   <= mag;
      s1_first_r <= (idx_r == '0);
      s1_end_r   <= row_end;
      s1_ctrl_r  <= ctrl;
      s2_sq_r    <= SQ_W'(s1_mag_r) * SQ_W'(s1_mag_r);
      s2_first_r <= s1_first_r;
      s2_end_r   <= s1_end_r;
      s2_ctrl_r  <= s1_ctrl_r;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rsdn_back.sv
// Back end: per row, integer square root (two bits a cycle), gain multiply,
// restoring divide by (row length - 1) with saturation, and output register.
// Depends on rsdn_pkg.
`default_nettype none

module rsdn_back #(
  parameter int SUM_W = 44
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire logic [SUM_W+rsdn_pkg::CTRL_W-1:0] q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rsdn_pkg::OUT_W-1:0]        out_ic_value,
  output logic                              out_batch_end
);

  localparam int LEN_W = rsdn_pkg::LEN_W;
  localparam int OUT_W = rsdn_pkg::OUT_W;
  localparam int R_W   = (SUM_W + 1) / 2;
  localparam int MUL_W = rsdn_pkg::GAIN_W + R_W;
  localparam int PR_W  = (MUL_W > OUT_W + rsdn_pkg::FRAC_BITS) ? MUL_W
                                                          : OUT_W + rsdn_pkg::FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_ROOT, S_MULT, S_CHECK, S_DIV, S_DONE
  } state_t;

  state_t               state_r;
  rsdn_pkg::row_ctrl_t  ctrl_r;
  logic [2*R_W-1:0]     x_r;
  logic [R_W+1:0]       rem_r;
  logic [R_W-1:0]       root_r;
  logic [PR_W-1:0]      prod_r;
  logic [LEN_W-1:0]     drem_r;
  logic [OUT_W-1:0]     dvd_r;
  logic [rsdn_pkg::CNT_W-1:0] cnt_r;
  logic                 out_valid_r, out_batch_end_r;
  logic [OUT_W-1:0]     out_ic_value_r;

  logic [R_W+1:0]   rem_cand, trial;
  logic             root_ge;
  logic [MUL_W-1:0] mul;
  logic [PR_W-1:0]  hi;
  logic             sat;
  logic [LEN_W:0]   div_t, div_d;
  logic             div_ge;
  logic             out_free;
  logic             out_load;
  rsdn_pkg::row_ctrl_t q_ctrl;

  assign q_ctrl = q_data[SUM_W +: rsdn_pkg::CTRL_W];

  assign rem_cand = {rem_r[R_W-1:0], x_r[2*R_W-1 -: 2]};
  assign trial    = {root_r, 2'b01};
  assign root_ge  = rem_cand >= trial;

  assign mul = MUL_W'(ctrl_r.gain) * MUL_W'(root_r);

  // Quotient overflows 32 bits when the part above them is not below the divisor.
  assign hi  = prod_r >> (OUT_W + rsdn_pkg::FRAC_BITS);
  assign sat = hi >= PR_W'(ctrl_r.len_m1);

  assign div_t  = {drem_r, dvd_r[OUT_W-1]};
  assign div_d  = {1'b0, ctrl_r.len_m1};
  assign div_ge = div_t >= div_d;

  assign out_free = !out_valid_r || out_ready;
  assign out_load = (state_r == S_DONE) && out_free;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  assign out_valid     = out_valid_r;
  assign out_ic_value  = out_ic_value_r;
  assign out_batch_end = out_batch_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load)                      out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ctrl_r  <= q_ctrl;
            x_r     <= (2*R_W)'(q_data[SUM_W-1:0]);
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= rsdn_pkg::CNT_W'(R_W - 1);
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          x_r <= x_r << 2;
          if (root_ge) begin
            rem_r  <= rem_cand - trial;
            root_r <= {root_r[R_W-2:0], 1'b1};
          end else begin
            rem_r  <= rem_cand;
            root_r <= {root_r[R_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= S_MULT;
        end
        S_MULT: begin
          prod_r  <= PR_W'(mul);
          state_r <= S_CHECK;
        end
        S_CHECK: begin
          if (sat) begin
            dvd_r   <= '1;
            state_r <= S_DONE;
          end else begin
            drem_r  <= hi[LEN_W-1:0];
            dvd_r   <= prod_r[rsdn_pkg::FRAC_BITS +: OUT_W];
            cnt_r   <= rsdn_pkg::CNT_W'(OUT_W - 1);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          // quotient bits shift in from the bottom as dividend bits leave the top
          drem_r <= div_ge ? LEN_W'(div_t - div_d) : div_t[LEN_W-1:0];
          dvd_r  <= {dvd_r[OUT_W-2:0], div_ge};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_ic_value_r  <= dvd_r;
            out_batch_end_r <= ctrl_r.last;
            state_r         <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/row_successive_difference_norm_top.sv
// Top level of the row successive-difference norm block: configuration
// registers, front end, row queue and back end. Depends on rsdn_pkg,
// rsdn_front, rsdn_queue and rsdn_back.
//
//   channel  | signals                                   | role
//   ---------+-------------------------------------------+-------------------------
//   in       | in_valid, in_ready, in_sample             | one sample per beat
//   out      | out_valid, out_ready, out_ic_value,       | one result per row
//            | out_batch_end                             |
//   cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | register writes, always ready
//
// Samples are taken one per cycle while in_ready is high; the front end
// runs a three-stage difference/square/accumulate pipeline. The back end
// takes one row at a time: pop, square root, gain multiply, saturation
// check, divide (skipped on saturation) and output, so short rows back up
// the 4-entry row queue and stall input. in_ready drops only when a row
// end finds the queue full. Reset is synchronous active low and returns
// the configuration registers to their defaults.
`default_nettype none

module row_successive_difference_norm_top #(
  parameter int SAMPLE_WIDTH   = 16,
  parameter int MAX_ROW_LENGTH = 4096
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    in_sample,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [rsdn_pkg::OUT_W-1:0]             out_ic_value,
  output logic                                   out_batch_end,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rsdn_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [rsdn_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SUM_FULL_W = 2 * SAMPLE_WIDTH + $clog2(MAX_ROW_LENGTH);
  localparam int SUM_W      = (SUM_FULL_W > 64) ? 64 : SUM_FULL_W;
  localparam int Q_W        = SUM_W + rsdn_pkg::CTRL_W;

  logic [rsdn_pkg::LEN_W-1:0]   row_length_r;
  logic [rsdn_pkg::GAIN_W-1:0]  gain_r;
  logic [rsdn_pkg::BATCH_W-1:0] batch_rows_r;

  logic           q_full, q_push, q_pop, q_valid;
  logic [Q_W-1:0] q_wdata, q_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_length_r <= rsdn_pkg::ROW_LENGTH_RST;
      gain_r       <= rsdn_pkg::GAIN_RST;
      batch_rows_r <= rsdn_pkg::BATCH_ROWS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rsdn_pkg::CFG_ROW_LENGTH: row_length_r <= cfg_data[rsdn_pkg::LEN_W-1:0];
        rsdn_pkg::CFG_GAIN:       gain_r       <= cfg_data[rsdn_pkg::GAIN_W-1:0];
        rsdn_pkg::CFG_BATCH_ROWS: batch_rows_r <= cfg_data[rsdn_pkg::BATCH_W-1:0];
        default: ;
      endcase
    end
  end

  rsdn_front #(
    .SAMPLE_W (SAMPLE_WIDTH),
    .MAX_LEN  (MAX_ROW_LENGTH),
    .SUM_W    (SUM_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_sample  (in_sample),
    .row_length (row_length_r),
    .gain       (gain_r),
    .batch_rows (batch_rows_r),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  rsdn_queue #(
    .DATA_W (Q_W),
    .DEPTH  (rsdn_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_valid (q_valid),
    .pop_data  (q_rdata)
  );

  rsdn_back #(
    .SUM_W (SUM_W)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_ic_value  (out_ic_value),
    .out_batch_end (out_batch_end)
  );

endmodule

`default_nettype wire
